/* hw/rtl/inverse_cdf_table_sampler_macros.svh */
// assertion helpers for the rtl files, used by icdf_queue
`ifndef INVERSE_CDF_TABLE_SAMPLER_MACROS_SVH
`define INVERSE_CDF_TABLE_SAMPLER_MACROS_SVH

// checked on every clock edge outside reset
`define ICDF_CHECK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every clock edge, reset included
`define ICDF_CHECK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* hw/rtl/icdf_pkg.sv */
package icdf_pkg;

   typedef enum logic [1:0] {
      KIND_SKIP,
      KIND_LOAD,
      KIND_SAMPLE,
      KIND_RANGE
   } item_kind_type;

   typedef struct packed {
      logic valid;
      logic err;
      logic neg;
   } tag_type;

   localparam int unsigned ONE_Q16    = 65536;
   localparam int unsigned CLAMP_Q16  = 65470;
   localparam int unsigned FRAC_W     = 17;
   localparam int unsigned STEP_W     = 16;
   localparam int unsigned DECAY_W    = 24;
   localparam int unsigned MEAN_W     = 42;
   localparam int unsigned MEAN_LO_W  = 21;
   localparam int unsigned DIVIDEND_W = 43;
   localparam int unsigned DIVISOR_W  = 17;
   localparam int unsigned TIME_W     = 37;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   localparam logic [1:0] CSR_FAST_DECAY = 2'd0;
   localparam logic [1:0] CSR_SLOW_DECAY = 2'd1;
   localparam logic [1:0] CSR_MIXING     = 2'd2;

endpackage

/* hw/rtl/icdf_queue.sv */
`include "inverse_cdf_table_sampler_macros.svh"

module icdf_queue #(
   parameter int W     = 8,
   parameter int DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output logic [W-1:0] head_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [W-1:0]  mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `ICDF_CHECK(a_no_overflow, push |-> !full, "request pushed into a full queue")
   `ICDF_CHECK(a_no_underflow, pop |-> head_valid, "pop from an empty queue")
   `ICDF_CHECK(a_count_up, (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1), "queue count lost a push")

endmodule

/* hw/rtl/icdf_front.sv */
module icdf_front import icdf_pkg::*; #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  logic                                     operation,
   input  logic [9:0]                               table_index,
   input  logic [FRAC_W-1:0]                        table_value,
   input  logic [FRAC_W-1:0]                        random_value,
   output logic                                     push,
   input  logic                                     full,
   output logic [2+2*$clog2(TABLE_SIZE)+FRAC_W-1:0] entry
);
   localparam int AW = $clog2(TABLE_SIZE);
   localparam int PW = FRAC_W + AW;

   logic              valid_ff, valid_in;
   logic              op_ff;
   logic [9:0]        index_ff;
   logic [FRAC_W-1:0] value_ff, random_ff;

   logic              take;
   logic [PW-1:0]     pos;
   logic [AW-1:0]     idx, addr0, addr1;
   logic [STEP_W-1:0] step;
   logic              top, in_range;
   logic [26:0]       index_ext;
   logic [FRAC_W-1:0] data;
   item_kind_type     kind;

   assign in_ready = !valid_ff || !full;
   assign take     = in_valid && in_ready;
   assign push     = valid_ff && !full;
   assign valid_in = take || (valid_ff && full);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff     <= operation;
         index_ff  <= table_index;
         value_ff  <= table_value;
         random_ff <= random_value;
      end
   end

   // scale into the table: integer part picks the entry, fraction is the step
   assign pos       = PW'(random_ff) * PW'(TABLE_SIZE - 1);
   assign idx       = pos[STEP_W +: AW];
   assign step      = pos[STEP_W-1:0];
   assign top       = (idx == AW'(TABLE_SIZE - 1));
   assign index_ext = 27'(index_ff);
   assign in_range  = (17'(index_ff) < 17'(TABLE_SIZE));

   always_comb begin
      kind  = KIND_SAMPLE;
      addr0 = idx;
      addr1 = top ? idx : idx + 1'b1;
      data  = {1'b0, (top ? {STEP_W{1'b0}} : step)};
      if (op_ff == OP_LOAD) begin
         kind  = in_range ? KIND_LOAD : KIND_SKIP;
         addr0 = index_ext[AW-1:0];
         addr1 = index_ext[AW-1:0];
         data  = value_ff;
      end else if (random_ff > FRAC_W'(ONE_Q16)) begin
         kind  = KIND_RANGE;
         addr0 = '0;
         addr1 = '0;
         data  = '0;
      end
   end

   assign entry = {kind, addr0, addr1, data};

endmodule

/* hw/rtl/icdf_back.sv */
module icdf_back import icdf_pkg::*; #(
   parameter int TABLE_SIZE = 1024
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     adv,
   input  logic                                     head_valid,
   input  logic [2+2*$clog2(TABLE_SIZE)+FRAC_W-1:0] head_data,
   output logic                                     pop,
   input  logic [DECAY_W-1:0]                       fast_decay,
   input  logic [DECAY_W-1:0]                       slow_decay,
   input  logic [FRAC_W-1:0]                        mixing,
   output tag_type                                  tag_o,
   output logic [DIVIDEND_W-1:0]                    dividend,
   output logic [DIVISOR_W-1:0]                     divisor
);
   localparam int AW = $clog2(TABLE_SIZE);
   localparam int EW = 2 + 2 * AW + FRAC_W;

   logic [FRAC_W-1:0] table_mem [TABLE_SIZE];

   item_kind_type     kind;
   logic [AW-1:0]     addr0, addr1;
   logic [FRAC_W-1:0] data;

   // coefficient path, registered in mix_slow_ff and then mean_ff
   logic [FRAC_W-1:0]           mix_sat;
   logic [FRAC_W+DECAY_W-1:0]   mix_slow_ff;
   logic [MEAN_W-1:0]           mean_ff;

   tag_type                     tag1_ff, tag2_ff, tag3_ff, tag4_ff, tag5_ff, tag6_ff;
   logic [FRAC_W-1:0]           rd0_ff, rd1_ff;
   logic [STEP_W-1:0]           step1_ff;
   logic [2*FRAC_W-1:0]         m0_ff, m1_ff;
   logic [2*FRAC_W:0]           msum;
   logic [18:0]                 x_raw;
   logic [STEP_W-1:0]           x_ff;
   logic [FRAC_W-1:0]           absf_ff, den4_ff, den5_ff, den6_ff;
   logic [MEAN_LO_W+FRAC_W-1:0] plo_ff, phi_ff;
   logic [MEAN_W+FRAC_W-1:0]    prod;
   logic [DIVIDEND_W-1:0]       a_ff;

   assign kind  = item_kind_type'(head_data[EW-1 -: 2]);
   assign addr0 = head_data[FRAC_W+AW +: AW];
   assign addr1 = head_data[FRAC_W +: AW];
   assign data  = head_data[FRAC_W-1:0];
   assign pop   = head_valid && adv;

   assign mix_sat = (mixing > FRAC_W'(ONE_Q16)) ? FRAC_W'(ONE_Q16) : mixing;

   always_ff @(posedge clock) begin
      mix_slow_ff <= (FRAC_W+DECAY_W)'(mix_sat) * (FRAC_W+DECAY_W)'(slow_decay);
      mean_ff     <= (MEAN_W'(fast_decay) * MEAN_W'(3) << 16) + MEAN_W'(mix_slow_ff);
   end

   always_ff @(posedge clock) begin
      if (pop && kind == KIND_LOAD) begin
         table_mem[addr0] <= data;
      end
      if (adv) begin
         rd0_ff <= table_mem[addr0];
         rd1_ff <= table_mem[addr1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
         tag4_ff <= '0;
         tag5_ff <= '0;
         tag6_ff <= '0;
      end else if (adv) begin
         tag1_ff.valid <= pop && (kind == KIND_SAMPLE || kind == KIND_RANGE);
         tag1_ff.err   <= (kind == KIND_RANGE);
         tag1_ff.neg   <= 1'b0;
         tag2_ff       <= tag1_ff;
         tag3_ff       <= tag2_ff;
         tag4_ff       <= '{valid: tag3_ff.valid, err: tag3_ff.err, neg: !x_ff[STEP_W-1]};
         tag5_ff       <= tag4_ff;
         tag6_ff       <= tag5_ff;
      end
   end

   assign msum  = (2*FRAC_W+1)'(m0_ff) + (2*FRAC_W+1)'(m1_ff);
   assign x_raw = msum[2*FRAC_W -: 19];
   assign prod  = (MEAN_W+FRAC_W)'(plo_ff) + ((MEAN_W+FRAC_W)'(phi_ff) << MEAN_LO_W);

   always_ff @(posedge clock) begin
      if (adv) begin
         step1_ff <= data[STEP_W-1:0];
         // interpolation weights
         m0_ff    <= (2*FRAC_W)'(rd0_ff) * (2*FRAC_W)'(FRAC_W'(ONE_Q16) - FRAC_W'(step1_ff));
         m1_ff    <= (2*FRAC_W)'(rd1_ff) * (2*FRAC_W)'(step1_ff);
         // clamp at 0.999
         x_ff     <= (x_raw > 19'(CLAMP_Q16)) ? STEP_W'(CLAMP_Q16) : x_raw[STEP_W-1:0];
         // |2x - 1| and 1 - x
         absf_ff  <= x_ff[STEP_W-1] ? FRAC_W'({x_ff, 1'b0}) - FRAC_W'(ONE_Q16)
                                    : FRAC_W'(ONE_Q16) - FRAC_W'({x_ff, 1'b0});
         den4_ff  <= FRAC_W'(ONE_Q16) - FRAC_W'(x_ff);
         // mean times |2x - 1|, split in two partial products
         plo_ff   <= (MEAN_LO_W+FRAC_W)'(mean_ff[MEAN_LO_W-1:0]) * (MEAN_LO_W+FRAC_W)'(absf_ff);
         phi_ff   <= (MEAN_LO_W+FRAC_W)'(mean_ff[MEAN_W-1:MEAN_LO_W])
                     * (MEAN_LO_W+FRAC_W)'(absf_ff);
         den5_ff  <= den4_ff;
         a_ff     <= prod[MEAN_W+FRAC_W-1:16];
         den6_ff  <= den5_ff;
      end
   end

   assign tag_o    = tag6_ff;
   assign dividend = a_ff;
   assign divisor  = den6_ff;

endmodule

/* hw/rtl/icdf_div.sv */
module icdf_div import icdf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  tag_type               tag_i,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output tag_type               tag_o,
   output logic [DIVIDEND_W-1:0] quotient
);
   localparam int N = DIVIDEND_W;

   tag_type               tag_s  [N+1];
   logic [DIVISOR_W-1:0]  rem_s  [N+1];
   logic [DIVIDEND_W-1:0] a_s    [N+1];
   logic [DIVIDEND_W-1:0] q_s    [N+1];
   logic [DIVISOR_W-1:0]  d_s    [N+1];

   tag_type               tag_ff [N];
   logic [DIVISOR_W-1:0]  rem_ff [N];
   logic [DIVIDEND_W-1:0] a_ff   [N];
   logic [DIVIDEND_W-1:0] q_ff   [N];
   logic [DIVISOR_W-1:0]  d_ff   [N];

   assign tag_s[0] = tag_i;
   assign rem_s[0] = '0;
   assign a_s[0]   = dividend;
   assign q_s[0]   = '0;
   assign d_s[0]   = divisor;

   // restoring division, one quotient bit per stage
   for (genvar s = 0; s < N; s++) begin : g_stage
      logic [DIVISOR_W:0] trial;
      logic               ge;

      assign trial = {rem_s[s], a_s[s][DIVIDEND_W-1]};
      assign ge    = (trial >= {1'b0, d_s[s]});

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[s] <= '0;
         end else if (en) begin
            tag_ff[s] <= tag_s[s];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[s] <= ge ? DIVISOR_W'(trial - {1'b0, d_s[s]}) : trial[DIVISOR_W-1:0];
            a_ff[s]   <= a_s[s] << 1;
            q_ff[s]   <= {q_s[s][DIVIDEND_W-2:0], ge};
            d_ff[s]   <= d_s[s];
         end
      end

      assign tag_s[s+1] = tag_ff[s];
      assign rem_s[s+1] = rem_ff[s];
      assign a_s[s+1]   = a_ff[s];
      assign q_s[s+1]   = q_ff[s];
      assign d_s[s+1]   = d_ff[s];
   end

   assign tag_o    = tag_s[N];
   assign quotient = q_s[N];

endmodule

/* hw/rtl/inverse_cdf_table_sampler.sv */
// channel | direction | handshake            | payload
// req     | in        | req_tvalid/tready    | tuser operation, tdata index/value/random
// rsp     | out       | rsp_tvalid/tready    | tuser range_error, tdata emission_time
// csr     | in        | csr_valid/csr_ready  | csr_index, csr_data (always ready)
//
// one request per cycle sustained while rsp_tready stays high; a sample reaches rsp through
// the front register, queue, six back stages, 43-stage restoring divider and output register
// reset clears control state only; the fraction table holds garbage until loaded
// rsp_tready low freezes the back pipeline; the front takes requests until the queue fills
// a fast decay write reaches mean_ff directly; slow decay and mixing pass mix_slow_ff first
module inverse_cdf_table_sampler import icdf_pkg::*; #(
   parameter int TABLE_SIZE  = 1024,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // table_index[9:0], table_value[26:10], random_value[43:27]
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // emission_time[36:0]
   output logic        rsp_tuser,   // range_error
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);
   localparam int AW = $clog2(TABLE_SIZE);
   localparam int EW = 2 + 2 * AW + FRAC_W;

   // configuration registers
   logic [DECAY_W-1:0] fast_ff, slow_ff;
   logic [FRAC_W-1:0]  mix_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_ff <= '0;
         slow_ff <= '0;
         mix_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FAST_DECAY: fast_ff <= csr_data;
            CSR_SLOW_DECAY: slow_ff <= csr_data;
            CSR_MIXING:     mix_ff  <= csr_data[FRAC_W-1:0];
            default:        ;
         endcase
      end
   end

   // back pipeline moves whenever the output register can take a word
   logic rsp_valid_ff;
   logic adv;
   assign adv = !rsp_valid_ff || rsp_tready;

   // front: accept and classify
   logic          push, full, pop, head_valid;
   logic [EW-1:0] entry, head_data;

   icdf_front #(.TABLE_SIZE(TABLE_SIZE)) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .operation    (req_tuser),
      .table_index  (req_tdata[9:0]),
      .table_value  (req_tdata[26:10]),
      .random_value (req_tdata[43:27]),
      .push         (push),
      .full         (full),
      .entry        (entry)
   );

   // decoupling queue
   icdf_queue #(.W(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   // back: table access, interpolation, numerator and denominator
   tag_type               back_tag, div_tag;
   logic [DIVIDEND_W-1:0] dividend, quotient;
   logic [DIVISOR_W-1:0]  divisor;

   icdf_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
      .clock      (clock),
      .reset      (reset),
      .adv        (adv),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .fast_decay (fast_ff),
      .slow_decay (slow_ff),
      .mixing     (mix_ff),
      .tag_o      (back_tag),
      .dividend   (dividend),
      .divisor    (divisor)
   );

   icdf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .tag_i    (back_tag),
      .dividend (dividend),
      .divisor  (divisor),
      .tag_o    (div_tag),
      .quotient (quotient)
   );

   // output register: apply the sign, force zero on range error
   logic [TIME_W-1:0] mag, time_in, time_ff;
   logic              err_ff;

   assign mag     = quotient[TIME_W-1:0];
   assign time_in = div_tag.err ? '0 : (div_tag.neg ? TIME_W'(~mag + 1'b1) : mag);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= div_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         time_ff <= time_in;
         err_ff  <= div_tag.err;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, time_ff};
   assign rsp_tuser  = err_ff;

endmodule
